// File: rtl/mht_pkg.sv
// ---------------------------------------------------------------------------
// MAC address hash table package
// Shared widths, codes and the request and result types.
// ---------------------------------------------------------------------------
package mht_pkg;

   localparam int SLOTS      = 256;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int COUNT_W    = $clog2(SLOTS + 1);
   localparam int PROBE_W    = $clog2(SLOTS + 1);
   localparam int MAC_W      = 48;
   localparam int ROLE_W     = 8;
   localparam int TIME_W     = 32;
   localparam int CNT_W      = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;
   localparam logic [31:0] LIFETIME_RESET = 32'd300;

   typedef enum logic [2:0] {
      FUNC_INSERT    = 3'd0,
      FUNC_LOOKUP    = 3'd1,
      FUNC_DELETE    = 3'd2,
      FUNC_READ_SLOT = 3'd3,
      FUNC_DEL_SLOT  = 3'd4,
      FUNC_EVICT     = 3'd5,
      FUNC_CLEAR     = 3'd6,
      FUNC_RST_CNT   = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_MISSING  = 3'd1,
      ST_INSERTED = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_DELETED  = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_USED  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   // Classified operation passed from the front end to the back end.
   typedef struct packed {
      func_type             func;
      logic [MAC_W-1:0]     mac;
      logic [SLOT_W-1:0]    home;
      logic [7:0]           slot_index;
      logic [ROLE_W-1:0]    role;
      logic [TIME_W-1:0]    expiry;
   } op_type;

   typedef struct packed {
      status_type           status;
      logic [7:0]           slot;
      logic [MAC_W-1:0]     mac_out;
      logic [ROLE_W-1:0]    role_out;
      logic [TIME_W-1:0]    expiry_out;
      logic [8:0]           removed_count;
      logic [8:0]           active_count;
      logic [CNT_W-1:0]     insert_count;
      logic [CNT_W-1:0]     delete_count;
   } result_type;

endpackage

// File: rtl/mht_front.sv
// ---------------------------------------------------------------------------
// MAC address hash table front end
// Accepts requests, hashes the address one byte a cycle and works out the
// expiry, then pushes the classified operation into the queue.
// ---------------------------------------------------------------------------
module mht_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [2:0]                in_func,
   input  logic [47:0]               in_mac,
   input  logic [7:0]                in_slot_index,
   input  logic [7:0]                in_role,
   input  logic                      in_role_sel,
   input  logic [31:0]               in_duration,
   input  logic                      in_duration_sel,
   input  logic [31:0]               in_now,
   input  logic [31:0]               lifetime,
   output logic                      op_valid,
   input  logic                      op_ready,
   output mht_pkg::op_type           op_data
);

   logic                     busy_ff, busy_in;
   logic [2:0]               byte_ff, byte_in;
   logic [31:0]              hash_ff, hash_in;
   logic [31:0]              mix;
   mht_pkg::op_type          op_ff, op_in;
   logic [7:0]               cur_byte;

   assign in_ready = !busy_ff;
   assign op_valid = busy_ff && (byte_ff == 3'd6);
   assign op_data  = op_ff;

   // Current address byte, most significant first.
   always_comb begin
      unique case (byte_ff)
         3'd0:    cur_byte = op_ff.mac[47:40];
         3'd1:    cur_byte = op_ff.mac[39:32];
         3'd2:    cur_byte = op_ff.mac[31:24];
         3'd3:    cur_byte = op_ff.mac[23:16];
         3'd4:    cur_byte = op_ff.mac[15:8];
         default: cur_byte = op_ff.mac[7:0];
      endcase
      mix = (hash_ff ^ {24'd0, cur_byte}) * mht_pkg::FNV_PRIME;
   end

   // One hash round a cycle; the home slot is the low bits of the hash.
   // The role select only applies to an insert; evict by role always uses the role field.
   always_comb begin
      busy_in = busy_ff;
      byte_in = byte_ff;
      hash_in = hash_ff;
      op_in   = op_ff;
      if (!busy_ff) begin
         if (in_valid) begin
            busy_in           = 1'b1;
            byte_in           = 3'd0;
            hash_in           = mht_pkg::FNV_BASIS;
            op_in.func        = mht_pkg::func_type'(in_func);
            op_in.mac         = in_mac;
            op_in.slot_index  = in_slot_index;
            op_in.role        = (in_role_sel ||
                                 mht_pkg::func_type'(in_func) != mht_pkg::FUNC_INSERT)
                                ? in_role : 8'd0;
            op_in.expiry      = in_now + (in_duration_sel ? in_duration : lifetime);
         end
      end else if (byte_ff != 3'd6) begin
         hash_in = mix;
         byte_in = byte_ff + 3'd1;
         if (byte_ff == 3'd5) begin
            op_in.home = mix[mht_pkg::SLOT_W-1:0];
         end
      end else if (op_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         byte_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         byte_ff <= byte_in;
      end
      hash_ff <= hash_in;
      op_ff   <= op_in;
   end

endmodule

// File: rtl/mht_queue.sv
// ---------------------------------------------------------------------------
// MAC address hash table operation queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
module mht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  mht_pkg::op_type   wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output mht_pkg::op_type   rd_data
);

   localparam int PTR_W = $clog2(mht_pkg::QUEUE_DEPTH);

   mht_pkg::op_type     entry_ff [mht_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [PTR_W:0]      cnt_ff, cnt_in;
   logic                push, pop;

   assign wr_ready = (cnt_ff != (PTR_W+1)'(mht_pkg::QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = entry_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wp_in  = push ? PTR_W'((32'(wp_ff) + 1) % mht_pkg::QUEUE_DEPTH) : wp_ff;
      rp_in  = pop  ? PTR_W'((32'(rp_ff) + 1) % mht_pkg::QUEUE_DEPTH) : rp_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/mht_back.sv
// ---------------------------------------------------------------------------
// MAC address hash table back end
// Probes and scans the slot stores one slot at a time (address,
// then registered read data) and writes results to an output register.
// After reset a clearing pass marks all 256 slots empty, one a cycle.
// ---------------------------------------------------------------------------
module mht_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_ready,
   input  mht_pkg::op_type   op_data,
   output logic              res_valid,
   input  logic              res_ready,
   output mht_pkg::result_type res_data
);

   localparam int SW = mht_pkg::SLOT_W;
   localparam int PW = mht_pkg::PROBE_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_EVAL  = 6'b000100,
      S_WRITE = 6'b001000,
      S_DONE  = 6'b010000,
      S_INIT  = 6'b100000
   } state_type;

   // Slot stores; the marks are cleared by a pass after reset.
   logic [1:0]                mark_mem [mht_pkg::SLOTS];
   logic [mht_pkg::MAC_W-1:0] key_mem [mht_pkg::SLOTS];
   logic [7:0]                role_mem [mht_pkg::SLOTS];
   logic [31:0]               exp_mem [mht_pkg::SLOTS];

   state_type           state_ff, state_in;
   mht_pkg::op_type     op_ff, op_in;
   logic [SW-1:0]       addr_ff, addr_in;
   logic [PW-1:0]       step_ff, step_in;
   logic [1:0]          rd_mark_ff;
   logic [47:0]         rd_key_ff;
   logic [7:0]          rd_role_ff;
   logic [31:0]         rd_exp_ff;
   logic                tomb_ok_ff, tomb_ok_in;
   logic [SW-1:0]       tomb_ff, tomb_in;
   logic [8:0]          occ_ff, occ_in;
   logic [31:0]         ins_ff, ins_in, del_ff, del_in;
   logic [8:0]          rem_ff, rem_in;
   logic                res_valid_ff, res_valid_in;
   mht_pkg::result_type res_ff, res_in;
   // Result under construction, kept apart from the output register.
   mht_pkg::result_type wk_ff, wk_in;
   // Write request to the stores.
   logic                wr_en;
   logic                wr_full;
   logic [SW-1:0]       wr_addr;
   logic [1:0]          wr_mark;
   logic                idx_ok;

   assign op_ready  = (state_ff == S_IDLE);
   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;
   assign idx_ok    = (32'(op_ff.slot_index) < mht_pkg::SLOTS);

   // Sequencer for probing and scanning.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      step_in      = step_ff;
      tomb_ok_in   = tomb_ok_ff;
      tomb_in      = tomb_ff;
      occ_in       = occ_ff;
      ins_in       = ins_ff;
      del_in       = del_ff;
      rem_in       = rem_ff;
      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      wk_in        = wk_ff;
      wr_en        = 1'b0;
      wr_full      = 1'b0;
      wr_addr      = addr_ff;
      wr_mark      = mht_pkg::MARK_TOMB;

      if (res_valid_ff && res_ready) begin
         res_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_mark = mht_pkg::MARK_EMPTY;
            addr_in = addr_ff + SW'(1);
            if (addr_ff == SW'(mht_pkg::SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (op_valid) begin
               op_in      = op_data;
               step_in    = '0;
               tomb_ok_in = 1'b0;
               rem_in     = '0;
               wk_in      = '0;
               wk_in.status = mht_pkg::ST_MISSING;
               unique case (op_data.func)
                  mht_pkg::FUNC_INSERT, mht_pkg::FUNC_LOOKUP, mht_pkg::FUNC_DELETE: begin
                     addr_in  = op_data.home;
                     state_in = S_READ;
                  end
                  mht_pkg::FUNC_READ_SLOT, mht_pkg::FUNC_DEL_SLOT: begin
                     addr_in  = SW'(op_data.slot_index);
                     state_in = S_READ;
                  end
                  mht_pkg::FUNC_EVICT, mht_pkg::FUNC_CLEAR: begin
                     addr_in  = '0;
                     state_in = S_READ;
                  end
                  default: begin
                     ins_in       = '0;
                     del_in       = '0;
                     wk_in.status = mht_pkg::ST_FOUND;
                     state_in     = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_READ;
            step_in  = step_ff + PW'(1);
            addr_in  = addr_ff + SW'(1);
            unique case (op_ff.func)
               mht_pkg::FUNC_INSERT: begin
                  if (rd_mark_ff == mht_pkg::MARK_USED && rd_key_ff == op_ff.mac) begin
                     wr_en = 1'b1; wr_full = 1'b1; wr_mark = mht_pkg::MARK_USED;
                     wk_in.status = mht_pkg::ST_UPDATED;
                     wk_in.slot   = 8'(addr_ff);
                     state_in = S_DONE;
                  end else if (rd_mark_ff == mht_pkg::MARK_EMPTY) begin
                     addr_in  = addr_ff;
                     state_in = S_WRITE;
                  end else begin
                     if (rd_mark_ff != mht_pkg::MARK_USED && !tomb_ok_ff) begin
                        tomb_ok_in = 1'b1;
                        tomb_in    = addr_ff;
                     end
                     if (step_ff == PW'(mht_pkg::SLOTS - 1)) begin
                        if (tomb_ok_ff || rd_mark_ff != mht_pkg::MARK_USED) begin
                           addr_in  = (tomb_ok_ff) ? tomb_ff : addr_ff;
                           state_in = S_WRITE;
                        end else begin
                           wk_in.status = mht_pkg::ST_FULL;
                           state_in = S_DONE;
                        end
                     end
                  end
               end
               mht_pkg::FUNC_LOOKUP, mht_pkg::FUNC_DELETE: begin
                  if (rd_mark_ff == mht_pkg::MARK_USED && rd_key_ff == op_ff.mac) begin
                     wk_in.slot = 8'(addr_ff);
                     if (op_ff.func == mht_pkg::FUNC_LOOKUP) begin
                        wk_in.status = mht_pkg::ST_FOUND;
                     end else begin
                        wr_en = 1'b1;
                        occ_in = occ_ff - 9'd1;
                        del_in = del_ff + 32'd1;
                        wk_in.status = mht_pkg::ST_DELETED;
                     end
                     state_in = S_DONE;
                  end else if (rd_mark_ff == mht_pkg::MARK_EMPTY ||
                               step_ff == PW'(mht_pkg::SLOTS - 1)) begin
                     state_in = S_DONE;
                  end
               end
               mht_pkg::FUNC_READ_SLOT, mht_pkg::FUNC_DEL_SLOT: begin
                  if (idx_ok && rd_mark_ff == mht_pkg::MARK_USED) begin
                     wk_in.slot = 8'(addr_ff);
                     if (op_ff.func == mht_pkg::FUNC_READ_SLOT) begin
                        wk_in.status     = mht_pkg::ST_FOUND;
                        wk_in.mac_out    = rd_key_ff;
                        wk_in.role_out   = rd_role_ff;
                        wk_in.expiry_out = rd_exp_ff;
                     end else begin
                        wr_en = 1'b1;
                        occ_in = occ_ff - 9'd1;
                        del_in = del_ff + 32'd1;
                        wk_in.status = mht_pkg::ST_DELETED;
                     end
                  end
                  state_in = S_DONE;
               end
               default: begin
                  if (rd_mark_ff == mht_pkg::MARK_USED &&
                      (op_ff.func == mht_pkg::FUNC_CLEAR || rd_role_ff == op_ff.role)) begin
                     wr_en  = 1'b1;
                     occ_in = occ_ff - 9'd1;
                     del_in = del_ff + 32'd1;
                     rem_in = rem_ff + 9'd1;
                  end
                  if (step_ff == PW'(mht_pkg::SLOTS - 1)) begin
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_WRITE: begin
            wr_en = 1'b1; wr_full = 1'b1; wr_mark = mht_pkg::MARK_USED;
            occ_in = occ_ff + 9'd1;
            ins_in = ins_ff + 32'd1;
            wk_in.status = mht_pkg::ST_INSERTED;
            wk_in.slot   = 8'(addr_ff);
            state_in = S_DONE;
         end
         default: begin
            // Hold the result until the output register is free.
            if (!res_valid_ff || res_ready) begin
               res_valid_in = 1'b1;
               res_in = wk_ff;
               res_in.removed_count = rem_ff;
               res_in.active_count  = occ_ff;
               res_in.insert_count  = ins_ff;
               res_in.delete_count  = del_ff;
               if ((op_ff.func == mht_pkg::FUNC_EVICT || op_ff.func == mht_pkg::FUNC_CLEAR)
                   && rem_ff != '0) begin
                  res_in.status = mht_pkg::ST_DELETED;
               end
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Store writes and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem[wr_addr] <= wr_mark;
      end
      if (wr_en && wr_full) begin
         key_mem[wr_addr]  <= op_ff.mac;
         role_mem[wr_addr] <= op_ff.role;
         exp_mem[wr_addr]  <= op_ff.expiry;
      end
      rd_mark_ff <= mark_mem[addr_ff];
      rd_key_ff  <= key_mem[addr_ff];
      rd_role_ff <= role_mem[addr_ff];
      rd_exp_ff  <= exp_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         occ_ff       <= '0;
         ins_ff       <= '0;
         del_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         occ_ff       <= occ_in;
         ins_ff       <= ins_in;
         del_ff       <= del_in;
         res_valid_ff <= res_valid_in;
      end
      op_ff      <= op_in;
      step_ff    <= step_in;
      tomb_ok_ff <= tomb_ok_in;
      tomb_ff    <= tomb_in;
      rem_ff     <= rem_in;
      res_ff     <= res_in;
      wk_ff      <= wk_in;
   end

endmodule

// File: rtl/mac_address_hash_table.sv
// ---------------------------------------------------------------------------
// MAC address hash table
// Open-addressing table of MAC addresses with linear probing.
// ---------------------------------------------------------------------------
// Each transaction passes through the front end (one FNV-1a hash round
// per address byte) and then the back end, which visits one slot at a time
// and reads the slot stores through one registered port; evict by role and
// clear scan all 256 slots. The front end hashes the next transaction while
// the back end works, and the result waits in an output register. After
// reset the back end marks every slot empty before it starts the first
// transaction; requests are accepted meanwhile and wait in the queue.
module mac_address_hash_table (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // func[2:0], mac[50:3], slot_index[58:51], role[66:59], role_sel[67],
   // duration[99:68], duration_sel[100], now[132:101]
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[2:0], slot[10:3], mac_out[58:11], role_out[66:59],
   // expiry_out[98:67], removed_count[107:99], active_count[116:108],
   // insert_count[148:117], delete_count[180:149]
   output logic [183:0]  rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data
);

   logic [31:0]          life_ff;
   logic                 fq_valid, fq_ready, qb_valid, qb_ready;
   mht_pkg::op_type      fq_data, qb_data;
   mht_pkg::result_type  res;

   // Default lifetime register.
   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff <= mht_pkg::LIFETIME_RESET;
      end else begin
         if (csr_wr_en) begin
            life_ff <= csr_wr_data;
         end
      end
   end

   mht_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .in_valid               (req_tvalid),
      .in_ready               (req_tready),
      .in_func                (req_tdata[2:0]),
      .in_mac                 (req_tdata[50:3]),
      .in_slot_index          (req_tdata[58:51]),
      .in_role                (req_tdata[66:59]),
      .in_role_sel            (req_tdata[67]),
      .in_duration            (req_tdata[99:68]),
      .in_duration_sel        (req_tdata[100]),
      .in_now                 (req_tdata[132:101]),
      .lifetime               (life_ff),
      .op_valid               (fq_valid),
      .op_ready               (fq_ready),
      .op_data                (fq_data)
   );

   mht_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   mht_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (qb_valid),
      .op_ready  (qb_ready),
      .op_data   (qb_data),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_data  (res)
   );

   // Result packing, first field in the lowest bits.
   assign rsp_tdata = {3'd0, res.delete_count, res.insert_count, res.active_count,
                       res.removed_count, res.expiry_out, res.role_out, res.mac_out,
                       res.slot, res.status};

endmodule
